@@ rtl/core/hatl_pkg.sv @@
// ----------------------------------------------------------------------------
// hatl_pkg
// Types, codes and the control program shared by the heap tree LCA block.
// ----------------------------------------------------------------------------
package hatl_pkg;

  localparam int MAX_NODES_DEFAULT = 128;
  localparam int DATA_W = 32;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] node_value;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] second_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ancestor_value;
    logic                     found;
    logic                     store_full;
  } out_t;

  localparam int PC_W = 3;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_SCAN  = 3'd0;
  localparam pc_t STEP_CHECK = 3'd1;
  localparam pc_t STEP_CLIMB = 3'd2;
  localparam pc_t STEP_FETCH = 3'd3;
  localparam pc_t STEP_EMIT  = 3'd4;

  typedef enum logic [1:0] {
    COND_NONE      = 2'd0,
    COND_SCAN_MORE = 2'd1,
    COND_ABSENT    = 2'd2,
    COND_UNEQUAL   = 2'd3
  } cond_t;

  typedef struct packed {
    logic  scan;
    logic  climb;
    logic  fetch;
    logic  emit;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic scan_more;
    logic absent;
    logic unequal;
  } status_t;

  localparam ctrl_t CTRL_IDLE = '{scan: 1'b0, climb: 1'b0, fetch: 1'b0, emit: 1'b0,
                                  cond: COND_NONE, target: STEP_SCAN};

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = CTRL_IDLE;
    case (pc)
      STEP_SCAN: begin
        w.scan   = 1'b1;
        w.cond   = COND_SCAN_MORE;
        w.target = STEP_SCAN;
      end
      STEP_CHECK: begin
        w.cond   = COND_ABSENT;
        w.target = STEP_EMIT;
      end
      STEP_CLIMB: begin
        w.climb  = 1'b1;
        w.cond   = COND_UNEQUAL;
        w.target = STEP_CLIMB;
      end
      STEP_FETCH: begin
        w.fetch = 1'b1;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
      end
      default: begin
        w.emit = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/heap_array_tree_lca.sv @@
// ----------------------------------------------------------------------------
// heap_array_tree_lca
// Lowest common ancestor over a level-order binary tree held in a node store.
// ----------------------------------------------------------------------------
// Append and clear leave busy low; they give no result.
// A query holds busy through the scan steps over the stored nodes, one check,
// then, when both values are stored, one heap step per cycle (up to twice the
// tree depth) plus one more, fetch, emit; if either is absent, emit follows.
// The result strobe rises as busy falls; the receiver cannot stall.
// Synchronous reset empties the store and clears the overflow flag.
module heap_array_tree_lca #(
  parameter int MAX_NODES = hatl_pkg::MAX_NODES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  hatl_pkg::in_t  item,
  output logic           strobe,
  output hatl_pkg::out_t result
);
  import hatl_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    accept;
  logic    launch;

  assign accept = start && !busy;
  assign launch = accept && (item.kind == KIND_QUERY);

  hatl_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .status (status),
    .ctrl   (ctrl),
    .active (busy)
  );

  hatl_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .ctrl   (ctrl),
    .status (status),
    .result (result),
    .strobe (strobe)
  );

endmodule

@@ rtl/core/hatl_sequencer.sv @@
// ----------------------------------------------------------------------------
// hatl_sequencer
// Step counter over the query program with conditional jumps.
// ----------------------------------------------------------------------------
module hatl_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              launch,
  input  hatl_pkg::status_t status,
  output hatl_pkg::ctrl_t   ctrl,
  output logic              active
);
  import hatl_pkg::*;

  pc_t   pc;
  pc_t   pc_next;
  ctrl_t word;
  logic  take;

  always_comb begin
    word = ucode(pc);
    case (word.cond)
      COND_NONE:      take = 1'b0;
      COND_SCAN_MORE: take = status.scan_more;
      COND_ABSENT:    take = status.absent;
      COND_UNEQUAL:   take = status.unequal;
      default:        take = 1'b0;
    endcase
    pc_next = take ? word.target : pc + pc_t'(1);
    ctrl    = active ? word : CTRL_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pc     <= STEP_SCAN;
    end else if (launch) begin
      active <= 1'b1;
      pc     <= STEP_SCAN;
    end else if (active) begin
      if (word.emit) begin
        active <= 1'b0;
      end
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/core/hatl_datapath.sv @@
// ----------------------------------------------------------------------------
// hatl_datapath
// Node store, scan compare, heap climb and result register.
// ----------------------------------------------------------------------------
module hatl_datapath #(
  parameter int MAX_NODES = hatl_pkg::MAX_NODES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  hatl_pkg::in_t     item,
  input  hatl_pkg::ctrl_t   ctrl,
  output hatl_pkg::status_t status,
  output hatl_pkg::out_t    result,
  output logic              strobe
);
  import hatl_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  logic signed [DATA_W-1:0] mem [MAX_NODES];
  logic signed [DATA_W-1:0] rdata;
  logic [IW-1:0]            rd_addr;
  logic [CW-1:0]            count;
  logic                     overflow;
  logic [CW-1:0]            idx;
  logic                     rd_valid;
  logic [IW-1:0]            rd_idx;
  logic signed [DATA_W-1:0] key_a;
  logic signed [DATA_W-1:0] key_b;
  logic                     hit_a;
  logic                     hit_b;
  logic [IW-1:0]            pos_a;
  logic [IW-1:0]            pos_b;
  logic                     do_write;
  logic                     launch;

  assign launch   = accept && (item.kind == KIND_QUERY);
  assign do_write = accept && (item.kind == KIND_APPEND) && (count < CW'(MAX_NODES));
  assign rd_addr  = ctrl.fetch ? pos_a : idx[IW-1:0];

  assign status.scan_more = idx < count;
  assign status.absent    = !(hit_a && hit_b);
  assign status.unequal   = pos_a != pos_b;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count[IW-1:0]] <= item.node_value;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      case (item.kind)
        KIND_APPEND: begin
          if (do_write) begin
            count <= count + CW'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
        KIND_CLEAR: begin
          count    <= '0;
          overflow <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
      hit_a    <= 1'b0;
      hit_b    <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= ctrl.emit;
      if (launch) begin
        idx      <= '0;
        rd_valid <= 1'b0;
        hit_a    <= 1'b0;
        hit_b    <= 1'b0;
      end else begin
        if (ctrl.scan) begin
          rd_valid <= status.scan_more;
          if (status.scan_more) begin
            idx <= idx + CW'(1);
          end
        end
        if (rd_valid && (rdata == key_a)) begin
          hit_a <= 1'b1;
        end
        if (rd_valid && (rdata == key_b)) begin
          hit_b <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      key_a <= item.first_value;
      key_b <= item.second_value;
    end
    if (ctrl.scan) begin
      rd_idx <= idx[IW-1:0];
    end
    if (rd_valid && (rdata == key_a)) begin
      pos_a <= rd_idx;
    end else if (ctrl.climb && status.unequal && (pos_a > pos_b)) begin
      pos_a <= (pos_a - IW'(1)) >> 1;
    end
    if (rd_valid && (rdata == key_b)) begin
      pos_b <= rd_idx;
    end else if (ctrl.climb && status.unequal && !(pos_a > pos_b)) begin
      pos_b <= (pos_b - IW'(1)) >> 1;
    end
    if (ctrl.emit) begin
      result.found          <= !status.absent;
      result.ancestor_value <= status.absent ? '0 : rdata;
      result.store_full     <= overflow;
    end
  end

endmodule
